// File: rtl/cbme_pkg.sv
// shared constants, register map and types for the cubic bezier motion evaluator
// no dependencies; imported by cbme_weights, cbme_lane and the top level
package cbme_pkg;

  localparam int COORD_WIDTH_DEF = 20;
  localparam int TIME_WIDTH_DEF  = 16;

  // pipeline depth: stages 0..4 build the weights, stages 5..10 run in the lanes
  localparam int NSTAGE   = 11;
  localparam int ST_LANE  = 5;
  localparam int NUM_AXES = 3;

  localparam int Q16W = 17;  // u, v in 0..1.0
  localparam int Q32W = 33;  // products of two q16 values, bernstein weights

  localparam logic [Q16W-1:0] ONE_Q16 = 17'h10000;

  localparam int POINT_W    = 60;
  localparam int SPAN_W     = 16;
  localparam int INV_W      = 32;
  localparam int INV_HALF_W = 16;

  localparam int CFG_DW = 64;
  localparam int CFG_AW = 6;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_POINT_A  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_POINT_B  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_POINT_C  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_POINT_D  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SPAN     = 3'd4;
  localparam logic [CFG_IW-1:0] REG_INV_SPAN = 3'd5;

  typedef logic [NSTAGE-1:0] stage_en_t;

  typedef struct packed {
    logic [Q16W-1:0] u;
    logic [Q16W-1:0] v;
    logic [Q32W-1:0] uu;
    logic [Q32W-1:0] uv;
    logic [Q32W-1:0] vv;
    logic [Q32W-1:0] b0;
    logic [Q32W-1:0] b1;
    logic [Q32W-1:0] b2;
    logic [Q32W-1:0] b3;
  } weights_t;

endpackage

// File: rtl/cbme_weights.sv
// time normalisation and bernstein weight pipeline, stages 0 to 4
// depends on cbme_pkg
module cbme_weights #(
  parameter int TIME_WIDTH = cbme_pkg::TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  cbme_pkg::stage_en_t        en,
  input  logic [TIME_WIDTH-1:0]      time_tick,
  input  logic [cbme_pkg::INV_W-1:0] inv_span,
  output cbme_pkg::weights_t         w
);
  import cbme_pkg::*;

  localparam int PRODW = TIME_WIDTH + INV_W;
  localparam int UFW   = PRODW - 16;
  localparam int CUBW  = Q32W + Q16W;

  logic [TIME_WIDTH-1:0] t_s0;
  logic [PRODW-1:0]      prod_s1;
  logic [Q16W-1:0]       u_s2, v_s2, u_s3, v_s3;
  logic [Q32W-1:0]       uu_s3, uv_s3, vv_s3;

  logic [UFW-1:0]        u_full;
  logic [Q16W-1:0]       u_sat;
  logic [2*Q16W-1:0]     uu_c, uv_c, vv_c;
  logic [CUBW-1:0]       c0, c1, c2, c3;
  logic [Q32W-1:0]       m1, m2;
  weights_t              w_next;

  // u = floor(t * inv / 2^16), clipped at 1.0
  assign u_full = prod_s1[PRODW-1:16];
  assign u_sat  = (u_full > UFW'(ONE_Q16)) ? ONE_Q16 : u_full[Q16W-1:0];

  assign uu_c = u_s2 * u_s2;
  assign uv_c = u_s2 * v_s2;
  assign vv_c = v_s2 * v_s2;

  assign c0 = vv_s3 * v_s3;
  assign c1 = uv_s3 * v_s3;
  assign c2 = uv_s3 * u_s3;
  assign c3 = uu_s3 * u_s3;
  assign m1 = c1[Q32W+15:16];
  assign m2 = c2[Q32W+15:16];

  always_comb begin
    w_next.u  = u_s3;
    w_next.v  = v_s3;
    w_next.uu = uu_s3;
    w_next.uv = uv_s3;
    w_next.vv = vv_s3;
    w_next.b0 = c0[Q32W+15:16];
    w_next.b1 = (m1 << 1) + m1;
    w_next.b2 = (m2 << 1) + m2;
    w_next.b3 = c3[Q32W+15:16];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_s0 <= time_tick;
    end
    if (en[1]) begin
      prod_s1 <= t_s0 * inv_span;
    end
    if (en[2]) begin
      u_s2 <= u_sat;
      v_s2 <= ONE_Q16 - u_sat;
    end
    if (en[3]) begin
      u_s3  <= u_s2;
      v_s3  <= v_s2;
      uu_s3 <= uu_c[Q32W-1:0];
      uv_s3 <= uv_c[Q32W-1:0];
      vv_s3 <= vv_c[Q32W-1:0];
    end
    if (en[4]) begin
      w <= w_next;
    end
  end

endmodule

// File: rtl/cbme_lane.sv
// one axis lane: position, velocity and acceleration, stages 5 to 10
// depends on cbme_pkg; fed by cbme_weights
module cbme_lane #(
  parameter int COORD_WIDTH = cbme_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  cbme_pkg::stage_en_t           en,
  input  logic signed [COORD_WIDTH-1:0] ca,
  input  logic signed [COORD_WIDTH-1:0] cb,
  input  logic signed [COORD_WIDTH-1:0] cc,
  input  logic signed [COORD_WIDTH-1:0] cd,
  input  logic [cbme_pkg::INV_W-1:0]    inv_span,
  input  cbme_pkg::weights_t            w,
  output logic signed [COORD_WIDTH-1:0] pos,
  output logic signed [31:0]            vel,
  output logic signed [31:0]            acc
);
  import cbme_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int EW   = CW + 2;
  localparam int PPW  = CW + Q32W + 1;
  localparam int PW   = CW + 36;
  localparam int VPW  = DW + Q32W + 1;
  localparam int VW   = CW + 37;
  localparam int QW   = VW - 16;
  localparam int APW  = EW + Q16W + 1;
  localparam int AW   = CW + 24;
  localparam int HW   = INV_HALF_W + 1;
  localparam int T1W  = 42;
  localparam int TCW  = (AW + 2 > T1W) ? AW + 2 : T1W;
  localparam int PQW  = PW - 32;
  localparam int ACCW = T1W + HW + 1;

  localparam logic signed [PW-1:0]  HALF_LSB = PW'(64'h8000_0000);
  localparam logic signed [PQW-1:0] POS_MAX  = PQW'((1 << (CW - 1)) - 1);
  localparam logic signed [PQW-1:0] POS_MIN  = -POS_MAX - PQW'(1);
  localparam logic signed [TCW-1:0] T1_LIM   = TCW'(64'h100_0000_0000);
  localparam logic signed [63:0]    S32_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0]    S32_MIN  = -64'sh0000_0000_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // control point differences, held steady between configuration writes
  logic signed [DW-1:0] dba, dcb, ddc;
  logic signed [EW-1:0] e1, e2;

  always_ff @(posedge clk) begin
    dba <= DW'(cb) - DW'(ca);
    dcb <= DW'(cc) - DW'(cb);
    ddc <= DW'(cd) - DW'(cc);
    e1  <= EW'(ca) - (EW'(cb) <<< 1) + EW'(cc);
    e2  <= EW'(cb) - (EW'(cc) <<< 1) + EW'(cd);
  end

  logic signed [HW-1:0] inv_hi, inv_lo;
  assign inv_hi = $signed({1'b0, inv_span[INV_W-1:INV_HALF_W]});
  assign inv_lo = $signed({1'b0, inv_span[INV_HALF_W-1:0]});

  // stage 5: products
  logic signed [PPW-1:0] pp0, pp1, pp2, pp3;
  logic signed [VPW-1:0] pv1, pv2, pv3;
  logic signed [APW-1:0] pa1, pa2;
  // stage 6: sums
  logic signed [PW-1:0]  ps;
  logic signed [QW-1:0]  dq;
  logic signed [AW-1:0]  as_s6;
  // stage 7
  logic signed [CW-1:0]     pos_s7, pos_s8, pos_s9;
  logic signed [QW+HW-1:0]  vhi, vlo;
  logic signed [AW+HW-1:0]  ahi, alo;
  // stage 8
  logic signed [31:0]       vel_s8, vel_s9;
  logic signed [T1W-1:0]    t1;
  // stage 9
  logic signed [T1W+HW-1:0] thi, tlo;

  logic signed [VW-1:0]      vsum_c, vs_c;
  logic signed [AW-1:0]      asum_c;
  logic signed [PW-1:0]      ps_c, psr_c;
  logic signed [PQW-1:0]     psq_c;
  logic signed [CW-1:0]      pos_c;
  logic signed [QW+34-1:0]   vfull_c;
  logic signed [QW+1:0]      vq_c;
  logic signed [AW+34-1:0]   afull_c;
  logic signed [AW+1:0]      aq_c;
  logic signed [TCW-1:0]     aqx_c, t1_c;
  logic signed [ACCW-1:0]    accs_c;

  always_comb begin
    ps_c   = PW'(pp0) + PW'(pp1) + PW'(pp2) + PW'(pp3);
    vsum_c = VW'(pv1) + (VW'(pv2) <<< 1) + VW'(pv3);
    vs_c   = (vsum_c <<< 1) + vsum_c;
    asum_c = AW'(pa1) + AW'(pa2);

    // position rounds to nearest, ties upward
    psr_c = ps + HALF_LSB;
    psq_c = $signed(psr_c[PW-1:32]);
    if (psq_c > POS_MAX) begin
      pos_c = POS_MAX[CW-1:0];
    end else if (psq_c < POS_MIN) begin
      pos_c = POS_MIN[CW-1:0];
    end else begin
      pos_c = psq_c[CW-1:0];
    end

    vfull_c = ((QW + 34)'(vhi) <<< 16) + (QW + 34)'(vlo);
    vq_c    = $signed(vfull_c[QW+33:32]);

    afull_c = ((AW + 34)'(ahi) <<< 16) + (AW + 34)'(alo);
    aq_c    = $signed(afull_c[AW+33:32]);
    aqx_c   = TCW'(aq_c);
    if (aqx_c > T1_LIM) begin
      t1_c = T1_LIM;
    end else if (aqx_c < -T1_LIM) begin
      t1_c = -T1_LIM;
    end else begin
      t1_c = aqx_c;
    end

    accs_c = ACCW'(thi) + ACCW'(tlo >>> 16);
  end

  always_ff @(posedge clk) begin
    if (en[ST_LANE]) begin
      pp0 <= ca * $signed({1'b0, w.b0});
      pp1 <= cb * $signed({1'b0, w.b1});
      pp2 <= cc * $signed({1'b0, w.b2});
      pp3 <= cd * $signed({1'b0, w.b3});
      pv1 <= dba * $signed({1'b0, w.vv});
      pv2 <= dcb * $signed({1'b0, w.uv});
      pv3 <= ddc * $signed({1'b0, w.uu});
      pa1 <= e1 * $signed({1'b0, w.v});
      pa2 <= e2 * $signed({1'b0, w.u});
    end
    if (en[ST_LANE+1]) begin
      ps    <= ps_c;
      dq    <= $signed(vs_c[VW-1:16]);
      as_s6 <= (asum_c <<< 2) + (asum_c <<< 1);
    end
    if (en[ST_LANE+2]) begin
      pos_s7 <= pos_c;
      vhi    <= dq * inv_hi;
      vlo    <= dq * inv_lo;
      ahi    <= as_s6 * inv_hi;
      alo    <= as_s6 * inv_lo;
    end
    if (en[ST_LANE+3]) begin
      pos_s8 <= pos_s7;
      vel_s8 <= sat32(64'(vq_c));
      t1     <= t1_c[T1W-1:0];
    end
    if (en[ST_LANE+4]) begin
      pos_s9 <= pos_s8;
      vel_s9 <= vel_s8;
      thi    <= t1 * inv_hi;
      tlo    <= t1 * inv_lo;
    end
    if (en[ST_LANE+5]) begin
      pos <= pos_s9;
      vel <= vel_s9;
      acc <= sat32(64'(accs_c));
    end
  end

endmodule

// File: rtl/cubic_bezier_motion_eval_unit.sv
// top level of the cubic bezier motion evaluator: register file, pipeline control,
// three axis lanes and the output merge; depends on cbme_pkg, cbme_weights, cbme_lane
//
// usage
//   configuration: apb-style port, 64-bit data, registers at byte address 8*i:
//     point_a, point_b, point_c, point_d (three packed signed coordinates, x low),
//     span_ticks, inv_span. write only while no transaction is in flight
//   input channel: in_valid / in_ready, one time_tick per transaction
//   output channel: out_valid / out_ready, position, velocity and acceleration
//     on x, y and z plus range_error; when time_tick exceeds span_ticks every
//     other field of the result is zero
//   pipeline: eleven register stages, 0 to 10, carry the accepted input
//     transaction to the output register
//   throughput: one transaction per cycle unless the output stalls; the 16x32
//     time scaling and per-lane partial-product multiplies each have their own stage
//   stall: each stage holds only while the one after it is full and held, so a
//     waiting result does not block new input until every stage is occupied;
//     in_ready is low only when the pipeline is full and out_ready is low
//   reset: synchronous, clears the stage valid bits and loads the register
//     reset values (points zero, span_ticks one, inv_span all ones)
module cubic_bezier_motion_eval_unit #(
  parameter int COORD_WIDTH = cbme_pkg::COORD_WIDTH_DEF,
  parameter int TIME_WIDTH  = cbme_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbme_pkg::CFG_AW-1:0] paddr,
  input  logic [cbme_pkg::CFG_DW-1:0] pwdata,
  output logic [cbme_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [TIME_WIDTH-1:0]       time_tick,
  // output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COORD_WIDTH-1:0] pos_x,
  output logic signed [COORD_WIDTH-1:0] pos_y,
  output logic signed [COORD_WIDTH-1:0] pos_z,
  output logic signed [31:0]          vel_x,
  output logic signed [31:0]          vel_y,
  output logic signed [31:0]          vel_z,
  output logic signed [31:0]          acc_x,
  output logic signed [31:0]          acc_y,
  output logic signed [31:0]          acc_z,
  output logic                        range_error
);
  import cbme_pkg::*;

  // configuration registers
  logic [POINT_W-1:0] point_a, point_b, point_c, point_d;
  logic [SPAN_W-1:0]  span_ticks;
  logic [INV_W-1:0]   inv_span;

  logic              cfg_write;
  logic [CFG_IW-1:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[CFG_AW-1:CFG_AW-CFG_IW];

  always_ff @(posedge clk) begin
    if (rst) begin
      point_a    <= '0;
      point_b    <= '0;
      point_c    <= '0;
      point_d    <= '0;
      span_ticks <= SPAN_W'(1);
      inv_span   <= '1;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_POINT_A:  point_a    <= pwdata[POINT_W-1:0];
        REG_POINT_B:  point_b    <= pwdata[POINT_W-1:0];
        REG_POINT_C:  point_c    <= pwdata[POINT_W-1:0];
        REG_POINT_D:  point_d    <= pwdata[POINT_W-1:0];
        REG_SPAN:     span_ticks <= pwdata[SPAN_W-1:0];
        REG_INV_SPAN: inv_span   <= pwdata[INV_W-1:0];
        default: ; // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_POINT_A:  prdata = CFG_DW'(point_a);
      REG_POINT_B:  prdata = CFG_DW'(point_b);
      REG_POINT_C:  prdata = CFG_DW'(point_c);
      REG_POINT_D:  prdata = CFG_DW'(point_d);
      REG_SPAN:     prdata = CFG_DW'(span_ticks);
      REG_INV_SPAN: prdata = CFG_DW'(inv_span);
      default:      prdata = '0;
    endcase
  end

  // pipeline control: a stage loads when it is empty or its successor loads
  logic [NSTAGE-1:0] vld;
  stage_en_t         en;
  logic [NSTAGE-1:0] err_s;

  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // range check travels alongside the item
  logic [TIME_WIDTH-1:0] span_cut;
  assign span_cut = TIME_WIDTH'(span_ticks);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      err_s[0] <= time_tick > span_cut;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (en[k]) begin
        err_s[k] <= err_s[k-1];
      end
    end
  end

  // shared time and weight pipeline
  weights_t w;

  cbme_weights #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_weights (
    .clk       (clk),
    .en        (en),
    .time_tick (time_tick),
    .inv_span  (inv_span),
    .w         (w)
  );

  // one lane per axis
  logic [63:0] pa_ext, pb_ext, pc_ext, pd_ext;
  assign pa_ext = 64'(point_a);
  assign pb_ext = 64'(point_b);
  assign pc_ext = 64'(point_c);
  assign pd_ext = 64'(point_d);

  logic signed [COORD_WIDTH-1:0] pos_l [NUM_AXES];
  logic signed [31:0]            vel_l [NUM_AXES];
  logic signed [31:0]            acc_l [NUM_AXES];

  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_lane
    cbme_lane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane (
      .clk      (clk),
      .en       (en),
      .ca       (pa_ext[ax*COORD_WIDTH +: COORD_WIDTH]),
      .cb       (pb_ext[ax*COORD_WIDTH +: COORD_WIDTH]),
      .cc       (pc_ext[ax*COORD_WIDTH +: COORD_WIDTH]),
      .cd       (pd_ext[ax*COORD_WIDTH +: COORD_WIDTH]),
      .inv_span (inv_span),
      .w        (w),
      .pos      (pos_l[ax]),
      .vel      (vel_l[ax]),
      .acc      (acc_l[ax])
    );
  end

  // merge: an out-of-range time forces every value to zero
  assign range_error = err_s[NSTAGE-1];
  assign pos_x = range_error ? '0 : pos_l[0];
  assign pos_y = range_error ? '0 : pos_l[1];
  assign pos_z = range_error ? '0 : pos_l[2];
  assign vel_x = range_error ? '0 : vel_l[0];
  assign vel_y = range_error ? '0 : vel_l[1];
  assign vel_z = range_error ? '0 : vel_l[2];
  assign acc_x = range_error ? '0 : acc_l[0];
  assign acc_y = range_error ? '0 : acc_l[1];
  assign acc_z = range_error ? '0 : acc_l[2];

`ifndef ASSERT_OFF
  // input is only refused when the whole pipeline is full behind a stalled output
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused while output side is not stalled");

  // an accepted transaction always occupies the first stage
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted transaction not held in first stage");

  // nothing leaves the block straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result presented straight after reset");
`endif

endmodule

// File: sim/cubic_bezier_motion_eval_unit_test.sv
`timescale 1ns / 100ps
// self-checking testbench for cubic_bezier_motion_eval_unit: apb register set-up,
// time samples in, position / velocity / acceleration out, checked against a local predictor
// depends on cbme_pkg and the rtl of the evaluator
module cubic_bezier_motion_eval_unit_test;
  import cbme_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int TW = TIME_WIDTH_DEF;

  localparam int CMAX = 2 ** (CW - 1) - 1;
  localparam int CMIN = -(2 ** (CW - 1));

  // indexes past the register map, writes there must leave everything alone
  localparam logic [CFG_IW-1:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [CFG_IW-1:0] REG_UNMAPPED_7 = 3'd7;

  localparam int NUM_SETTINGS      = 12;
  localparam int SAMPLES_PER_PHASE = 96;
  localparam int GAP_LONG_MAX      = 40;
  // the worst case run time is several times shorter than this limit
  localparam int RUN_LIMIT_NS      = 5_000_000;

  // one result of the evaluator, also used for what was actually seen
  typedef struct packed {
    logic [TW-1:0]      tick;
    logic               range_err;
    logic [2:0][CW-1:0] pos;
    logic [2:0][31:0]   vel;
    logic [2:0][31:0]   acc;
  } motion_sample_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  // block inputs, all known from time zero
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [CFG_AW-1:0]   paddr     = '0;
  logic [CFG_DW-1:0]   pwdata    = '0;
  logic                in_valid  = 1'b0;
  logic [TW-1:0]       time_tick = '0;
  logic                out_ready = 1'b0;

  // block outputs
  logic [CFG_DW-1:0]   prdata;
  logic                pready;
  logic                in_ready;
  logic                out_valid;
  logic signed [CW-1:0] pos_x, pos_y, pos_z;
  logic signed [31:0]  vel_x, vel_y, vel_z;
  logic signed [31:0]  acc_x, acc_y, acc_z;
  logic                range_error;

  cubic_bezier_motion_eval_unit dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .time_tick   (time_tick),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .vel_z       (vel_z),
    .acc_x       (acc_x),
    .acc_y       (acc_y),
    .acc_z       (acc_z),
    .range_error (range_error)
  );

  // local copy of the register file, only changed while the pipeline is empty
  logic [POINT_W-1:0] point_reg [4];
  logic [SPAN_W-1:0]  span_reg = 16'd1;
  logic [INV_W-1:0]   inv_reg  = 32'hFFFF_FFFF;

  // time samples waiting to be sent, and the results they must produce
  logic [TW-1:0]      pending_ticks [$];
  motion_sample_t     expected_samples [$];

  int  samples_queued = 0;
  int  results_seen   = 0;
  int  beyond_span    = 0;
  int  setting_count  = 0;
  int  fail_count     = 0;
  int  send_gap       = 0;
  int  recv_stall     = 0;
  bit  idle_on        = 1'b1;

  initial begin
    for (int k = 0; k < 4; k++) point_reg[k] = '0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // signed coordinate of one axis out of a packed control point
  function automatic longint axis_coord(logic [POINT_W-1:0] pt, int axis);
    logic signed [CW-1:0] raw;
    raw = pt[axis*CW +: CW];
    return raw;
  endfunction

  // floor(x * m / 2^sh), exact over the full product width
  function automatic longint scale_floor(longint x, logic [31:0] m, int sh);
    logic signed [127:0] prod;
    prod = x * $signed({1'b0, m});
    return longint'(prod >>> sh);
  endfunction

  function automatic longint clamp_width(longint x, int w);
    longint top;
    top = (longint'(1) <<< (w - 1)) - 1;
    if (x > top) return top;
    if (x < -top - 1) return -top - 1;
    return x;
  endfunction

  // position, scaled derivatives and range flag for one time sample
  function automatic motion_sample_t eval_motion(logic [TW-1:0] t);
    motion_sample_t r;
    longint u, v, uu, uv, vv, w0, w1, w2, w3;
    longint a, b, c, d, pos_sum, vel_sum, acc_sum, first_scale, lim;
    r = '0;
    r.tick = t;
    // past the end of the motion everything but the flag is zero
    if (t > span_reg) begin
      r.range_err = 1'b1;
      return r;
    end
    // normalised time in q16, capped at 1.0 when the reciprocal is too large
    u = (longint'(t) * longint'(inv_reg)) >>> 16;
    if (u > 65536) u = 65536;
    v  = 65536 - u;
    uu = u * u;
    uv = u * v;
    vv = v * v;
    // bernstein weights in q32, each truncated on its own
    w0 = (vv * v) >>> 16;
    w1 = 3 * ((uv * v) >>> 16);
    w2 = 3 * ((uv * u) >>> 16);
    w3 = (uu * u) >>> 16;
    lim = longint'(1) <<< 40;
    for (int k = 0; k < 3; k++) begin
      a = axis_coord(point_reg[REG_POINT_A], k);
      b = axis_coord(point_reg[REG_POINT_B], k);
      c = axis_coord(point_reg[REG_POINT_C], k);
      d = axis_coord(point_reg[REG_POINT_D], k);
      // position: round to nearest with ties upward
      pos_sum = a * w0 + b * w1 + c * w2 + d * w3;
      r.pos[k] = CW'(clamp_width((pos_sum + (longint'(1) <<< 31)) >>> 32, CW));
      // velocity: q32 sum floored to q16, then times alpha
      vel_sum = 3 * ((b - a) * vv + 2 * (c - b) * uv + (d - c) * uu);
      r.vel[k] = 32'(clamp_width(scale_floor(vel_sum >>> 16, inv_reg, 32), 32));
      // acceleration: alpha applied twice, clamped in between
      acc_sum = 6 * ((a - 2 * b + c) * v + (b - 2 * c + d) * u);
      first_scale = scale_floor(acc_sum, inv_reg, 32);
      if (first_scale > lim) first_scale = lim;
      if (first_scale < -lim) first_scale = -lim;
      r.acc[k] = 32'(clamp_width(scale_floor(first_scale, inv_reg, 16), 32));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: one time sample per transaction, random gaps between them
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, GAP_LONG_MAX);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      // transaction taken at this edge: predict with the current registers
      if (in_valid && in_ready) begin
        expected_samples.push_back(eval_motion(time_tick));
      end
      // valid and payload only move once the held item has gone
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          in_valid  <= 1'b1;
          time_tick <= pending_ticks.pop_front();
          send_gap = idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: back-pressure and field-by-field comparison
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [TW-1:0] tick, logic [31:0] want,
                             logic [31:0] got);
    if (got !== want) begin
      if (fail_count < 10) begin
        $display("mismatch on %s for tick %0d: expected %h, got %h", name, tick, want, got);
      end
      fail_count++;
    end
  endtask

  task automatic check_result();
    motion_sample_t want, got;
    if (expected_samples.size() == 0) begin
      if (fail_count < 10) $display("result with no time sample outstanding");
      fail_count++;
      return;
    end
    want = expected_samples.pop_front();
    got           = '0;
    got.range_err = range_error;
    got.pos       = {pos_z, pos_y, pos_x};
    got.vel       = {vel_z, vel_y, vel_x};
    got.acc       = {acc_z, acc_y, acc_x};
    if (want.range_err) beyond_span++;
    check_field("range_error", want.tick, want.range_err, got.range_err);
    for (int k = 0; k < 3; k++) begin
      check_field($sformatf("pos[%0d]", k), want.tick, want.pos[k], got.pos[k]);
      check_field($sformatf("vel[%0d]", k), want.tick, want.vel[k], got.vel[k]);
      check_field($sformatf("acc[%0d]", k), want.tick, want.acc[k], got.acc[k]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        check_result();
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) recv_stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // register writes and stimulus helpers
  // ---------------------------------------------------------------------------

  // setup cycle, access cycle, register lands on the edge that ends the access
  task automatic reg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_POINT_A, REG_POINT_B, REG_POINT_C, REG_POINT_D: point_reg[idx] = data[POINT_W-1:0];
      REG_SPAN:     span_reg = data[SPAN_W-1:0];
      REG_INV_SPAN: inv_reg  = data[INV_W-1:0];
      default: ;
    endcase
  endtask

  // three coordinates packed x low, spare top bits random so masking is exercised
  function automatic logic [63:0] pack_point(int x, int y, int z);
    logic [31:0] xs, ys, zs;
    xs = x;
    ys = y;
    zs = z;
    return {4'($urandom), zs[CW-1:0], ys[CW-1:0], xs[CW-1:0]};
  endfunction

  // 0: any bit pattern, 1: small coordinates, 2: coordinates at the extremes
  function automatic logic [63:0] random_point(int shape);
    int c [3];
    if (shape == 0) return {$urandom, $urandom};
    for (int k = 0; k < 3; k++) begin
      if (shape == 1) c[k] = $urandom_range(0, 4000) - 2000;
      else c[k] = $urandom_range(0, 1) ? CMAX : CMIN;
    end
    return pack_point(c[0], c[1], c[2]);
  endfunction

  task automatic queue_tick(logic [TW-1:0] t);
    pending_ticks.push_back(t);
    samples_queued++;
  endtask

  // mostly inside the span, the end points often, a share beyond it
  function automatic logic [TW-1:0] pick_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return span_reg;
    if (r < 15) return '0;
    if (r < 85 || span_reg == '1) return $urandom_range(0, int'(span_reg));
    return $urandom_range(int'(span_reg) + 1, 65535);
  endfunction

  // sender holds off until every outstanding result has come back
  task automatic wait_for_results();
    while (results_seen != samples_queued) @(posedge clk);
  endtask

  task automatic load_random_setting(int phase);
    int shape, pick;
    logic [SPAN_W-1:0] span;
    logic [INV_W-1:0]  inv;
    shape = (phase == 0) ? 2 : $urandom_range(0, 2);
    reg_write(REG_POINT_A, random_point(shape));
    reg_write(REG_POINT_B, random_point(shape));
    reg_write(REG_POINT_C, random_point(shape));
    reg_write(REG_POINT_D, random_point(shape));
    pick = $urandom_range(0, 9);
    if (phase == 0) span = '1;
    else if (phase == NUM_SETTINGS - 1) span = 16'd1;
    else begin
      case (pick)
        0:       span = '0;
        1:       span = 16'd1;
        2:       span = '1;
        3, 4, 5: span = $urandom_range(2, 64);
        default: span = $urandom_range(2, 65535);
      endcase
    end
    // a consistent reciprocal most of the time, sometimes deliberately off
    pick = $urandom_range(0, 19);
    if (pick == 0) inv = $urandom;
    else if (pick == 1 || span == '0) inv = '1;
    else if (pick == 2) inv = '0;
    else inv = 32'(64'hFFFF_FFFF / span);
    reg_write(REG_SPAN, {$urandom, 16'($urandom), span});
    reg_write(REG_INV_SPAN, {$urandom, inv});
    if ($urandom_range(0, 3) == 0) begin
      reg_write($urandom_range(0, 1) ? REG_UNMAPPED_6 : REG_UNMAPPED_7, {$urandom, $urandom});
    end
    setting_count++;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset values: points at the origin, span of one tick, reciprocal all ones
    setting_count++;
    queue_tick(16'd0);
    queue_tick(16'd1);
    queue_tick(16'd2);
    queue_tick('1);
    wait_for_results();

    // coordinates at both extremes on a one-tick span: derivatives saturate
    reg_write(REG_POINT_A, pack_point(CMAX, CMAX, CMAX));
    reg_write(REG_POINT_B, pack_point(CMIN, CMIN, CMIN));
    reg_write(REG_POINT_C, pack_point(CMAX, CMAX, CMAX));
    reg_write(REG_POINT_D, pack_point(CMIN, CMIN, CMIN));
    setting_count++;
    queue_tick(16'd0);
    queue_tick(16'd1);
    wait_for_results();

    // span of 100 with a matching reciprocal, samples across and past the end
    reg_write(REG_POINT_A, pack_point(CMIN, CMAX, 0));
    reg_write(REG_POINT_B, pack_point(1000, -3000, 5000));
    reg_write(REG_POINT_C, pack_point(-70000, 256, CMAX));
    reg_write(REG_POINT_D, pack_point(CMAX, CMIN, -1));
    reg_write(REG_SPAN, 64'd100);
    reg_write(REG_INV_SPAN, 64'(64'h1_0000_0000 / 100));
    setting_count++;
    queue_tick(16'd0);
    queue_tick(16'd1);
    queue_tick(16'd50);
    queue_tick(16'd99);
    queue_tick(16'd100);
    queue_tick(16'd101);
    queue_tick('1);
    wait_for_results();

    // zero duration: only tick zero lies inside
    reg_write(REG_SPAN, 64'd0);
    setting_count++;
    queue_tick(16'd0);
    queue_tick(16'd1);
    wait_for_results();

    // reciprocal far too large for the span, u pins at one; unmapped writes ignored
    reg_write(REG_SPAN, {48'hFFFF_FFFF_FFFF, 16'd1000});
    reg_write(REG_INV_SPAN, '1);
    reg_write(REG_UNMAPPED_6, '1);
    reg_write(REG_UNMAPPED_7, '1);
    setting_count++;
    queue_tick(16'd0);
    queue_tick(16'd500);
    queue_tick(16'd1000);
    wait_for_results();

    // zero reciprocal: the curve never leaves its start point
    reg_write(REG_INV_SPAN, 64'd0);
    setting_count++;
    queue_tick(16'd0);
    queue_tick(16'd700);
    wait_for_results();

    // random phases, each on a fresh register setting; every fourth one runs flat out
    for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
      load_random_setting(phase);
      idle_on = (phase % 4 != 1);
      for (int n = 0; n < SAMPLES_PER_PHASE; n++) queue_tick(pick_tick());
      wait_for_results();
    end

    // let any stray result show up before the books are closed
    repeat (2 * NSTAGE) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $display("%0d expected results never arrived", expected_samples.size());
      fail_count += expected_samples.size();
    end
    $display("checked %0d motion samples, %0d of them past the span, over %0d register settings",
             results_seen, beyond_span, setting_count);
    $display("field mismatches and protocol errors: %0d", fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog in case the pipeline hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results outstanding", samples_queued - results_seen);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
rtl/cbme_pkg.sv
rtl/cbme_weights.sv
rtl/cbme_lane.sv
rtl/cubic_bezier_motion_eval_unit.sv
sim/cubic_bezier_motion_eval_unit_test.sv
